// ----- design/unary_word_count_parser_defines.svh -----
// assertion macros shared by the word count parser modules
`ifndef UNARY_WORD_COUNT_PARSER_DEFINES_SVH
`define UNARY_WORD_COUNT_PARSER_DEFINES_SVH

// condition holds at every clock edge out of reset
`define UWC_ASSERT_HOLDS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define UWC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define UWC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/uwc_pkg.sv -----
// types, constants and helpers of the unary word count parser
package uwc_pkg;

	// letters kept per word, range 1 to 64
	localparam int WORD_CAP = 64;

	// letter ring between parser and emitter, deeper than one capped word
	localparam int RING_AW    = 7;
	localparam int RING_DEPTH = 1 << RING_AW;
	localparam int PTR_W      = RING_AW + 1;

	localparam int LET_W = 5;
	localparam int LEN_W = 7;
	localparam int CNT_W = 16;

	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5a;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_Z = 8'h7a;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       text_end;
	} in_item_t;

	typedef struct packed {
		logic [6:0]       letter;
		logic [CNT_W-1:0] pair_count;
		logic [LEN_W-1:0] word_length;
		logic             last_letter;
	} out_item_t;

	// finished word waiting for the emitter
	typedef struct packed {
		logic [LEN_W-1:0] length;
		logic [CNT_W-1:0] count;
	} word_desc_t;

	// letter ring write port
	typedef struct packed {
		logic               en;
		logic [RING_AW-1:0] addr;
		logic [LET_W-1:0]   data;
	} ram_wr_t;

	function automatic logic is_letter(input logic [7:0] b);
		return ((b >= CH_UP_A) && (b <= CH_UP_Z)) || ((b >= CH_LOW_A) && (b <= CH_LOW_Z));
	endfunction

	// letter folded to 0..25
	function automatic logic [LET_W-1:0] fold_index(input logic [7:0] b);
		logic [7:0] t;
		t = ((b >= CH_UP_A) && (b <= CH_UP_Z)) ? (b - CH_UP_A) : (b - CH_LOW_A);
		return t[LET_W-1:0];
	endfunction

endpackage

// ----- design/unary_word_count_parser.sv -----
// top level of the unary word count parser
// a word's letters pass the word queue and the registered ring read into the result queue
// throughput: one byte accepted per cycle unless full, one letter emitted per cycle while
//   the result queue has room, set by the single ring read port and two entry word queue
// input stalls while two finished words wait or the 128 entry letter ring is full
// reset: asynchronous, active low; clears phase, counters, pointers and both queues
module unary_word_count_parser import uwc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  item,
	input  logic      pop,
	output logic      empty,
	output out_item_t result
);

	ram_wr_t            ram_wr;
	logic               q_full;
	logic               q_push;
	word_desc_t         q_desc;
	logic               q_pop;
	logic               q_valid;
	word_desc_t         q_head;
	logic               rd_en;
	logic [RING_AW-1:0] rd_addr;
	logic [LET_W-1:0]   rd_data;
	logic [PTR_W-1:0]   rd_ptr;

	// parser front end
	uwc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.rd_ptr (rd_ptr),
		.q_full (q_full),
		.q_push (q_push),
		.q_desc (q_desc),
		.ram_wr (ram_wr)
	);

	// finished word hand-off
	uwc_word_queue u_word_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_desc (q_desc),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (q_head)
	);

	// letter ring
	uwc_ram #(
		.AW (RING_AW),
		.DW (LET_W)
	) u_ring (
		.clk     (clk),
		.wr_en   (ram_wr.en),
		.wr_addr (ram_wr.addr),
		.wr_data (ram_wr.data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// letter emitter
	uwc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.rd_ptr  (rd_ptr),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule

// ----- design/uwc_ram.sv -----
// simple dual port ram with registered read
module uwc_ram #(
	parameter int AW = 7,
	parameter int DW = 5
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem_q [1 << AW];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- design/uwc_front.sv -----
// byte parser: phase machine, letter ring writes and word hand-off
module uwc_front import uwc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  in_item_t         item,
	input  logic [PTR_W-1:0] rd_ptr,
	input  logic             q_full,
	output logic             q_push,
	output word_desc_t       q_desc,
	output ram_wr_t          ram_wr
);

	localparam logic [1:0] PH_LOOK = 2'd0;
	localparam logic [1:0] PH_WORD = 2'd1;
	localparam logic [1:0] PH_ONES = 2'd2;

	logic [1:0]       phase_q, phase_n;
	logic [LEN_W-1:0] held_q, held_n;
	logic [CNT_W-1:0] ones_q, ones_n;
	logic [PTR_W-1:0] wr_ptr_q, wr_ptr_n;
	logic             accept;
	logic             letter_in;
	logic             one_in;
	logic             store;
	logic             commit;
	logic [PTR_W-1:0] used;

	// stall while the word queue or the letter ring has no room
	assign used   = wr_ptr_q - rd_ptr;
	assign full   = q_full || (used == PTR_W'(RING_DEPTH));
	assign accept = push && !full;

	assign letter_in = is_letter(item.text_byte);
	assign one_in    = (item.text_byte == CH_ONE);

	// next phase and counters
	always_comb begin
		phase_n  = phase_q;
		held_n   = held_q;
		ones_n   = ones_q;
		wr_ptr_n = wr_ptr_q;
		store    = 1'b0;
		commit   = 1'b0;
		if (item.text_end) begin
			if (phase_q == PH_ONES) begin
				commit = 1'b1;
			end else begin
				wr_ptr_n = wr_ptr_q - PTR_W'(held_q);
			end
			phase_n = PH_LOOK;
			held_n  = '0;
			ones_n  = '0;
		end else begin
			unique case (phase_q)
				PH_WORD: begin
					if (letter_in) begin
						if (held_q < LEN_W'(WORD_CAP)) begin
							store    = 1'b1;
							held_n   = held_q + LEN_W'(1);
							wr_ptr_n = wr_ptr_q + PTR_W'(1);
						end
					end else if (one_in) begin
						ones_n  = CNT_W'(1);
						phase_n = PH_ONES;
					end else begin
						// word without ones is dropped
						wr_ptr_n = wr_ptr_q - PTR_W'(held_q);
						held_n   = '0;
						phase_n  = PH_LOOK;
					end
				end
				PH_ONES: begin
					if (one_in) begin
						if (ones_q != '1) begin
							ones_n = ones_q + CNT_W'(1);
						end
					end else begin
						commit = 1'b1;
						ones_n = '0;
						if (letter_in) begin
							store    = 1'b1;
							held_n   = LEN_W'(1);
							wr_ptr_n = wr_ptr_q + PTR_W'(1);
							phase_n  = PH_WORD;
						end else begin
							held_n  = '0;
							phase_n = PH_LOOK;
						end
					end
				end
				default: begin
					// looking for a word, also the unused code
					if (letter_in) begin
						store    = 1'b1;
						held_n   = LEN_W'(1);
						wr_ptr_n = wr_ptr_q + PTR_W'(1);
						phase_n  = PH_WORD;
					end else begin
						held_n  = '0;
						phase_n = PH_LOOK;
					end
				end
			endcase
		end
	end

	// ring write and word hand-off
	assign ram_wr.en   = accept && store;
	assign ram_wr.addr = wr_ptr_q[RING_AW-1:0];
	assign ram_wr.data = fold_index(item.text_byte);

	assign q_push       = accept && commit;
	assign q_desc.length = held_q;
	assign q_desc.count  = ones_q;

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LOOK;
			held_q   <= '0;
			ones_q   <= '0;
			wr_ptr_q <= '0;
		end else if (accept) begin
			phase_q  <= phase_n;
			held_q   <= held_n;
			ones_q   <= ones_n;
			wr_ptr_q <= wr_ptr_n;
		end
	end

endmodule

// ----- design/uwc_word_queue.sv -----
// two entry queue of finished words between parser and emitter
module uwc_word_queue import uwc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  word_desc_t push_desc,
	output logic       full,
	input  logic       pop,
	output logic       valid,
	output word_desc_t head
);

`include "unary_word_count_parser_defines.svh"

	word_desc_t entry_q [2];
	logic       wr_idx_q;
	logic       rd_idx_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign valid = (count_q != 2'd0);
	assign head  = entry_q[rd_idx_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_idx_q] <= push_desc;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= 1'b0;
			rd_idx_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_idx_q <= ~wr_idx_q;
			end
			if (pop) begin
				rd_idx_q <= ~rd_idx_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	`UWC_ASSERT_HOLDS(a_count_range, count_q != 2'd3, "word queue level out of range")
	`UWC_ASSERT_IMPLIES(a_no_overflow, push, count_q != 2'd2, "word pushed into full queue")
	`UWC_ASSERT_IMPLIES(a_no_underflow, pop, count_q != 2'd0, "word popped from empty queue")

endmodule

// ----- design/uwc_back.sv -----
// emitter: reads letters of queued words from the ring into the result queue
module uwc_back import uwc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  word_desc_t         q_head,
	output logic               q_pop,
	output logic               rd_en,
	output logic [RING_AW-1:0] rd_addr,
	input  logic [LET_W-1:0]   rd_data,
	output logic [PTR_W-1:0]   rd_ptr,
	input  logic               pop,
	output logic               empty,
	output out_item_t          result
);

`include "unary_word_count_parser_defines.svh"

	logic [PTR_W-1:0] rd_ptr_q;
	logic [5:0]       idx_q;
	logic             valid_s1;
	logic [CNT_W-1:0] count_s1;
	logic [LEN_W-1:0] length_s1;
	logic             last_s1;
	out_item_t        ofifo_q [4];
	logic [1:0]       owr_q;
	logic [1:0]       ord_q;
	logic [2:0]       ocnt_q;
	logic [2:0]       pending;
	logic             issue;
	logic             last;
	logic             ofifo_pop;

	// issue a read only when the result queue has room for it, counting the letter in the ram read
	assign pending = ocnt_q + 3'(valid_s1);
	assign issue   = q_valid && (pending <= 3'd3);
	assign last    = (({1'b0, idx_q} + LEN_W'(1)) == q_head.length);
	assign q_pop   = issue && last;

	assign rd_en   = issue;
	assign rd_addr = rd_ptr_q[RING_AW-1:0];
	assign rd_ptr  = rd_ptr_q;

	// letter walk over the head word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			idx_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			if (issue) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
				idx_q    <= last ? 6'd0 : idx_q + 6'd1;
			end
		end
	end

	// word fields travelling alongside the ram read
	always_ff @(posedge clk) begin
		if (issue) begin
			count_s1  <= q_head.count;
			length_s1 <= q_head.length;
			last_s1   <= last;
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			ofifo_q[owr_q].letter      <= CH_LOW_A[6:0] + {2'b00, rd_data};
			ofifo_q[owr_q].pair_count  <= count_s1;
			ofifo_q[owr_q].word_length <= length_s1;
			ofifo_q[owr_q].last_letter <= last_s1;
		end
	end

	assign empty     = (ocnt_q == 3'd0);
	assign ofifo_pop = pop && !empty;
	assign result    = ofifo_q[ord_q];

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (valid_s1) begin
				owr_q <= owr_q + 2'd1;
			end
			if (ofifo_pop) begin
				ord_q <= ord_q + 2'd1;
			end
			ocnt_q <= ocnt_q + 3'(valid_s1) - 3'(ofifo_pop);
		end
	end

	`UWC_ASSERT_IMPLIES(a_ofifo_room, valid_s1, (ocnt_q != 3'd4) || ofifo_pop,
		"letter lands in full result queue")
	`UWC_ASSERT_NEXT(a_rd_ptr_step, issue, rd_ptr_q == $past(rd_ptr_q) + PTR_W'(1),
		"ring read pointer did not advance on issue")
	`UWC_ASSERT_IMPLIES(a_pop_on_last, q_pop, issue && last,
		"word released before its final letter")

endmodule

// ----- tb/unary_word_count_parser_tb.sv -----
// self-checking testbench for the unary word count parser
`timescale 1ns / 1ps

module unary_word_count_parser_tb;
	import uwc_pkg::*;

	// parse phases tracked by the predictor
	typedef enum logic [1:0] {
		SEEK_WORD,
		IN_WORD,
		COUNT_ONES
	} scan_phase_e;

	// expected letter stream of finished words, checked in order
	class word_scoreboard;
		scan_phase_e     scan;
		logic [LET_W-1:0] held_letters [WORD_CAP];
		logic [LEN_W-1:0] held;
		logic [CNT_W-1:0] ones;
		out_item_t        letter_q [$];
		int               errors;
		int               letters_ok;
		int               words_ok;
		int               capped_words;
		int               top_count;

		function new();
			scan = SEEK_WORD;
			held = '0;
			ones = '0;
			errors = 0;
			letters_ok = 0;
			words_ok = 0;
			capped_words = 0;
			top_count = 0;
		endfunction

		// setting bit 5 maps upper case onto lower case and nothing else onto a letter
		function bit is_alpha(logic [7:0] b);
			logic [7:0] low;
			low = b | 8'h20;
			return (low >= CH_LOW_A) && (low <= CH_LOW_Z);
		endfunction

		function void hold_letter(logic [7:0] b);
			logic [7:0] low;
			low = (b | 8'h20) - CH_LOW_A;
			if (held < WORD_CAP) begin
				held_letters[held] = low[LET_W-1:0];
				held++;
			end
		endfunction

		// queue one result per held letter, only when ones followed the word
		function void release_word();
			out_item_t r;
			if (held == 0 || ones == 0)
				return;
			for (int i = 0; i < held; i++) begin
				r.letter      = 7'(CH_LOW_A + held_letters[i]);
				r.pair_count  = ones;
				r.word_length = held;
				r.last_letter = (i == held - 1);
				letter_q.push_back(r);
			end
		endfunction

		// accepted input transfer
		function void note_transfer(in_item_t it);
			if (it.text_end) begin
				if (scan == COUNT_ONES)
					release_word();
				scan = SEEK_WORD;
				held = '0;
				ones = '0;
				return;
			end
			case (scan)
				IN_WORD: begin
					if (is_alpha(it.text_byte)) begin
						hold_letter(it.text_byte);
					end else if (it.text_byte == CH_ONE) begin
						ones = 1;
						scan = COUNT_ONES;
					end else begin
						scan = SEEK_WORD;
						held = '0;
					end
				end
				COUNT_ONES: begin
					if (it.text_byte == CH_ONE) begin
						if (ones != '1)
							ones++;
					end else begin
						release_word();
						held = '0;
						ones = '0;
						if (is_alpha(it.text_byte)) begin
							hold_letter(it.text_byte);
							scan = IN_WORD;
						end else begin
							scan = SEEK_WORD;
						end
					end
				end
				default: begin
					if (is_alpha(it.text_byte)) begin
						held = '0;
						hold_letter(it.text_byte);
						scan = IN_WORD;
					end else begin
						scan = SEEK_WORD;
					end
				end
			endcase
		endfunction

		function void compare_field(string name, int want, int got, logic xz);
			if (xz || got != want) begin
				errors++;
				$display("%0t: %s expected %0d, got %0d%s", $time, name, want, got,
					xz ? " (unknown bits)" : "");
			end
		endfunction

		// accepted result transfer
		function void check_transfer(out_item_t got);
			out_item_t want;
			if (letter_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got letter %0d count %0d",
					$time, got.letter, got.pair_count);
				return;
			end
			want = letter_q.pop_front();
			compare_field("letter", want.letter, got.letter, ^got.letter === 1'bx);
			compare_field("pair_count", want.pair_count, got.pair_count,
				^got.pair_count === 1'bx);
			compare_field("word_length", want.word_length, got.word_length,
				^got.word_length === 1'bx);
			compare_field("last_letter", want.last_letter, got.last_letter,
				^got.last_letter === 1'bx);
			letters_ok++;
			if (want.last_letter) begin
				words_ok++;
				if (want.word_length == WORD_CAP)
					capped_words++;
				if (want.pair_count > top_count)
					top_count = want.pair_count;
			end
		endfunction

		function int pending();
			return letter_q.size();
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      full;
	in_item_t  item = '0;
	logic      pop = 1'b0;
	logic      empty;
	out_item_t result;

	bit             calm = 1'b0;
	int             bytes_sent = 0;
	word_scoreboard sb = new();

	unary_word_count_parser u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

	always #5 clk = ~clk;

	// result side: check each transfer, then stall at random
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_transfer(result);
		pop <= calm || ($urandom_range(99) >= 27);
	end

	// one input transfer, with random gaps ahead of it
	task automatic send_byte(input logic [7:0] b, input logic e);
		in_item_t it;
		it.text_byte = b;
		it.text_end  = e;
		while (!calm && $urandom_range(99) < 27) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		do
			@(posedge clk);
		while (full);
		sb.note_transfer(it);
		bytes_sent++;
	endtask

	function automatic logic [7:0] any_letter();
		logic [7:0] base;
		base = $urandom_range(1) ? CH_UP_A : CH_LOW_A;
		return base + 8'($urandom_range(25));
	endfunction

	// any byte that neither extends a word nor counts as a one
	function automatic logic [7:0] any_break();
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (sb.is_alpha(b) || b == CH_ONE);
		return b;
	endfunction

	task automatic send_word(input int len);
		repeat (len)
			send_byte(any_letter(), 1'b0);
	endtask

	// well-formed word with random content, or a broken one
	task automatic send_sequence();
		int len;
		int n_ones;
		int pick;
		len = ($urandom_range(11) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 8);
		pick = $urandom_range(9);
		n_ones = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(7, 40) : $urandom_range(1, 6);
		send_word(len);
		repeat (n_ones)
			send_byte(CH_ONE, 1'b0);
		// next word's letter ends this one on its own
		case ($urandom_range(3))
			0: ;
			1, 2: send_byte(any_break(), 1'b0);
			default: send_byte(8'($urandom_range(255)), 1'b1);
		endcase
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 4))
			send_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: case folding, range edges, odd bytes, end of text in each phase
		send_byte(CH_ONE, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(CH_UP_A, 1'b0);
		send_byte(CH_LOW_Z, 1'b0);
		send_byte(CH_ONE, 1'b0);
		send_byte(CH_ONE, 1'b0);
		send_byte(CH_UP_Z, 1'b0);
		send_byte(CH_LOW_A, 1'b0);
		send_byte(CH_ONE, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h4d, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h71, 1'b0);
		send_byte(CH_ONE, 1'b0);
		send_byte(8'hff, 1'b1);
		send_byte(8'h00, 1'b1);
		send_byte(8'h62, 1'b0);
		send_byte(CH_ONE, 1'b1);
		send_byte(8'h42, 1'b0);
		send_byte(CH_ONE, 1'b0);
		send_byte(8'h40, 1'b0);
		send_byte(8'h5b, 1'b0);
		send_byte(8'h60, 1'b0);
		send_byte(8'h7b, 1'b0);
		send_byte(8'h7f, 1'b0);
		send_byte(8'h43, 1'b0);
		send_byte(CH_ONE, 1'b0);
		send_byte(8'h55, 1'b1);

		// random words and noise, with a stretch of back-to-back transfers
		while (bytes_sent < 410) begin
			calm = (bytes_sent > 150) && (bytes_sent < 260);
			if ($urandom_range(99) < 15)
				send_noise();
			else
				send_sequence();
		end
		calm = 1'b0;
		send_byte(8'h00, 1'b1);
		push <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d bytes sent, %0d words of %0d letters matched", bytes_sent,
			sb.words_ok, sb.letters_ok);
		$display("%0d words cut to the letter cap, highest count %0d", sb.capped_words,
			sb.top_count);
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#10ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
